FILE: hdl/deec_pkg.sv
// shared constants and types for the debounced edge event counter
package deec_pkg;

    // number of sensor channels handled side by side
    localparam int CHANNELS    = 4;
    // width of the sensor level field in the input transaction
    localparam int LEVEL_BITS  = 4;
    localparam int TIME_W      = 32;
    localparam int DEBOUNCE_W  = 16;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam int SCORE_W     = 32;
    localparam int EDGES_W     = 3;
    // per-sample hit count, wide enough for the largest channel count
    localparam int CNT_W       = 6;
    localparam logic [EDGES_W-1:0] EDGES_MAX = 3'd7;

    // packed transaction widths, rounded up to whole bytes
    localparam int S_DATA_W    = ((LEVEL_BITS + TIME_W + 7) / 8) * 8;
    localparam int M_DATA_W    = ((SCORE_W + EDGES_W + 7) / 8) * 8;

    // what the lanes hand to the merge stage for one accepted sample
    typedef struct packed {
        logic                accept;
        logic                hold;
        logic [CHANNELS-1:0] hits;
    } merge_in_t;

    // one result transaction
    typedef struct packed {
        logic [EDGES_W-1:0] edges_counted;
        logic [SCORE_W-1:0] score;
    } result_t;

endpackage

FILE: hdl/deec_lane.sv
// one sensor channel: falling edge detect with per-channel debounce timer
module deec_lane (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 accept,
    input  logic                                 level,
    input  logic [deec_pkg::TIME_W-1:0]          now_ms,
    input  logic [deec_pkg::DEBOUNCE_W-1:0]      window_ms,
    output logic                                 hit
);

    logic                            prev_level_reg;
    logic [deec_pkg::TIME_W-1:0]     last_edge_reg;
    logic [deec_pkg::TIME_W-1:0]     elapsed;

    // wrapping time since the last counted edge, compared to the debounce window
    always_comb begin
        elapsed = now_ms - last_edge_reg;
        hit     = !level && prev_level_reg &&
                  (elapsed > {{(deec_pkg::TIME_W - deec_pkg::DEBOUNCE_W){1'b0}}, window_ms});
    end

    // level history and edge timestamp, updated once per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= 1'b0;
            last_edge_reg  <= '0;
        end else if (accept) begin
            prev_level_reg <= level;
            if (hit) begin
                last_edge_reg <= now_ms;
            end
        end
    end

endmodule

FILE: hdl/deec_merge.sv
// merge stage: counts lane hits, keeps the score and buffers results
module deec_merge (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  deec_pkg::merge_in_t               lanes,
    output logic                              in_ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    output deec_pkg::result_t                 out_result
);

    logic [deec_pkg::SCORE_W-1:0]  score_reg;
    logic [deec_pkg::SCORE_W-1:0]  score_next;
    logic [deec_pkg::CNT_W-1:0]    hit_count;
    deec_pkg::result_t             new_result;
    deec_pkg::result_t             out_reg;
    deec_pkg::result_t             skid_reg;
    logic                          out_valid_reg;
    logic                          skid_valid_reg;
    logic                          pop;

    // popcount of lane hits and the new score
    always_comb begin
        hit_count = '0;
        for (int i = 0; i < deec_pkg::CHANNELS; i++) begin
            hit_count = hit_count + deec_pkg::CNT_W'(lanes.hits[i]);
        end
        if (lanes.hold) begin
            score_next               = '0;
            new_result.edges_counted = '0;
        end else begin
            score_next = score_reg +
                         {{(deec_pkg::SCORE_W - deec_pkg::CNT_W){1'b0}}, hit_count};
            if (hit_count > deec_pkg::CNT_W'(deec_pkg::EDGES_MAX)) begin
                new_result.edges_counted = deec_pkg::EDGES_MAX;
            end else begin
                new_result.edges_counted = hit_count[deec_pkg::EDGES_W-1:0];
            end
        end
        new_result.score = score_next;
    end

    // running score
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            score_reg <= '0;
        end else if (lanes.accept) begin
            score_reg <= score_next;
        end
    end

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_result = out_reg;

    // output register plus skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= lanes.accept;
            end else begin
                out_valid_reg  <= lanes.accept;
            end
        end else if (out_valid_reg) begin
            if (lanes.accept) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (lanes.accept) begin
            out_valid_reg <= 1'b1;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
                if (lanes.accept) begin
                    skid_reg <= new_result;
                end
            end else if (lanes.accept) begin
                out_reg <= new_result;
            end
        end else if (out_valid_reg) begin
            if (lanes.accept) begin
                skid_reg <= new_result;
            end
        end else if (lanes.accept) begin
            out_reg <= new_result;
        end
    end

`ifndef NO_ASSERTIONS
    // a buffered skid result always has a result ahead of it
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |=> out_valid_reg)
        else $error("skid entry left without an output result");

    // a stalled result is never dropped
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("stalled result lost");

    // clear hold leaves the score at zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        lanes.accept && lanes.hold |=> score_reg == '0)
        else $error("score not cleared by clear hold");
`endif

endmodule

FILE: hdl/debounced_edge_event_counter_core.sv
// top level of the debounced edge event counter
//
//  port group       dir   payload
//  s_t*             in    tdata: sensor_levels, now_ms; tuser: clear_hold
//  m_t*             out   tdata: score, edges_counted
//  cfg_wr_*         in    debounce window in ms
//
// one transaction per clock while s_tready is high: every lane compares its wrapping
// elapsed time and the merge stage adds the hit count to the score (clear_hold zeroes
// it) in the accept cycle. a result is registered in the output or skid register.
// aresetn is synchronous: levels low, edge times zero, score zero, debounce 50.
// on a stall the output register and a one-entry skid stage hold up to two
// results; s_tready drops only while the skid entry is full.
module debounced_edge_event_counter_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [deec_pkg::S_DATA_W-1:0]       s_tdata,   // sensor_levels, now_ms, zero pad
    input  logic                                s_tuser,   // clear_hold
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [deec_pkg::M_DATA_W-1:0]       m_tdata,   // score, edges_counted, zero pad
    input  logic                                cfg_wr_en,
    input  logic [deec_pkg::DEBOUNCE_W-1:0]     cfg_wr_data
);

    localparam int TIME_LO = deec_pkg::LEVEL_BITS;
    localparam int TIME_HI = deec_pkg::LEVEL_BITS + deec_pkg::TIME_W - 1;

    logic [deec_pkg::DEBOUNCE_W-1:0]  debounce_reg;
    logic [deec_pkg::CHANNELS-1:0]    hits;
    logic                             accept;
    deec_pkg::merge_in_t              merge_in;
    deec_pkg::result_t                result;

    assign accept = s_tvalid && s_tready;

    // debounce setting
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= deec_pkg::DEBOUNCE_RESET;
        end else if (cfg_wr_en) begin
            debounce_reg <= cfg_wr_data;
        end
    end

    // one lane per channel, channels past the level field read low
    for (genvar i = 0; i < deec_pkg::CHANNELS; i++) begin : g_lane
        logic lane_level;
        if (i < deec_pkg::LEVEL_BITS) begin : g_in
            assign lane_level = s_tdata[i];
        end else begin : g_low
            assign lane_level = 1'b0;
        end
        deec_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .accept      (accept),
            .level       (lane_level),
            .now_ms      (s_tdata[TIME_HI:TIME_LO]),
            .window_ms   (debounce_reg),
            .hit         (hits[i])
        );
    end

    always_comb begin
        merge_in.accept = accept;
        merge_in.hold   = s_tuser;
        merge_in.hits   = hits;
    end

    // score, hit count and output buffering
    deec_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .lanes      (merge_in),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // pack the result transaction
    assign m_tdata = {{(deec_pkg::M_DATA_W - deec_pkg::SCORE_W - deec_pkg::EDGES_W){1'b0}},
                      result.edges_counted, result.score};

endmodule
